@@ src/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Loop chunk scheduler package
// Shared request codes, the register index, datapath widths and the layout of
// one per-thread state entry.
// ----------------------------------------------------------------------------
package lcs_pkg;

	// request codes
	typedef enum logic [1:0] {
		FN_STATIC_START = 2'd0,
		FN_STATIC_NEXT  = 2'd1,
		FN_DYN_START    = 2'd2,
		FN_DYN_NEXT     = 2'd3
	} func_t;

	// register index, taken from paddr[2]
	localparam logic REG_TEAM_SIZE = 1'b0;

	localparam int TID_W   = 7;   // thread number
	localparam int IDX_W   = 32;  // loop index values
	localparam int CNT_W   = 33;  // iteration count, chunk size
	localparam int CUR_W   = 34;  // iteration cursor, result values
	localparam int DIV_NW  = 34;  // divider dividend / quotient
	localparam int DIV_DW  = 32;  // divider divisor

	// one entry of the per-thread state memory
	typedef struct packed {
		logic [IDX_W-1:0] base;
		logic [IDX_W-1:0] step;
		logic [CNT_W-1:0] chunk;
		logic [CUR_W-1:0] cursor;
		logic [CNT_W-1:0] count;
	} thr_ent_t;

endpackage

@@ src/lcs_div.sv @@
// ----------------------------------------------------------------------------
// Loop chunk scheduler divider
// Unsigned restoring divider, one quotient bit per cycle. done pulses for one
// cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module lcs_div
	import lcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;

	logic [DIV_DW:0]   shifted;
	logic [DIV_DW+1:0] trial;

	assign shifted = {rem_q, quo_q[DIV_NW-1]};
	assign trial   = {1'b0, shifted} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			// keep the partial remainder when the trial goes negative
			if (!trial[DIV_DW+1]) begin
				rem_q <= trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ src/loop_chunk_scheduler.sv @@
// ----------------------------------------------------------------------------
// Loop chunk scheduler
// Hands out iteration chunks of a worksharing loop to the threads of a team,
// in static (per-thread round-robin) or dynamic (shared cursor) mode.
// ----------------------------------------------------------------------------
// A next request goes straight to planning; a start first divides for the
// iteration count, and a static start with the default chunk divides again;
// each division holds the sequencer until done; a request given no chunk
// skips the multiply. One item at a time, busy high until the result cycle;
// the receiver cannot stall. Reset clears control, sets team_size to 1 and
// the shared loop to empty; per-thread memory holds garbage until written.
module loop_chunk_scheduler
	import lcs_pkg::*;
#(
	parameter int MAX_THREADS = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              func,
	input  logic [TID_W-1:0]        thread_id,
	input  logic signed [IDX_W-1:0] loop_first,
	input  logic signed [IDX_W-1:0] loop_limit,
	input  logic signed [IDX_W-1:0] loop_step,
	input  logic signed [IDX_W-1:0] chunk_request,
	// result channel
	output logic                    done,
	output logic                    has_chunk,
	output logic signed [CUR_W-1:0] chunk_first,
	output logic signed [CUR_W-1:0] chunk_stop,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int SW    = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int NTID  = 2 ** TID_W;
	localparam int PW    = 8 + CNT_W;      // product of an 8-bit factor and a chunk
	localparam int SUMW  = PW + 2;         // cursor plus product plus chunk

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_CNT_GO   = 8'b0000_0010,
		ST_CNT_WAIT = 8'b0000_0100,
		ST_CH_GO    = 8'b0000_1000,
		ST_CH_WAIT  = 8'b0001_0000,
		ST_PLAN     = 8'b0010_0000,
		ST_DECIDE   = 8'b0100_0000,
		ST_MUL      = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0] team_q;
	logic [7:0] team_eff;
	logic [7:0] team_m1;
	logic       cfg_wr;

	// captured request
	func_t             func_q;
	logic [TID_W-1:0]  tid_q;
	logic [SW-1:0]     slot_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  step_q;
	logic [IDX_W-1:0]  req_q;
	logic [CUR_W-1:0]  num_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  chunk_q;
	logic [PW-1:0]     p_q;

	// shared dynamic loop
	logic [CUR_W-1:0]  sh_cursor_q;
	logic [CNT_W-1:0]  sh_count_q;
	logic [IDX_W-1:0]  sh_base_q;
	logic [IDX_W-1:0]  sh_step_q;
	logic [CNT_W-1:0]  sh_chunk_q;

	// per-thread memory
	thr_ent_t          thr_mem [MAX_THREADS];
	thr_ent_t          rd_q;
	thr_ent_t          wr_data;
	logic              mem_we;
	logic [SW-1:0]     slot_tab [NTID];
	logic [SW-1:0]     slot_w;

	// chunk bounds and value products
	logic [CUR_W-1:0]  s_q;
	logic [CUR_W-1:0]  e_q;
	logic [IDX_W-1:0]  stp_q;
	logic [CUR_W-1:0]  first_acc_q;
	logic [CUR_W-1:0]  stop_acc_q;
	logic [CUR_W-1:0]  mp_q;
	logic [2:0]        mcnt_q;

	// results
	logic              done_q;
	logic              has_chunk_q;
	logic [CUR_W-1:0]  chunk_first_q;
	logic [CUR_W-1:0]  chunk_stop_q;

	logic accept;
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// ------------------------------------------------------------------------
	// Configuration port: one register, byte address 0.
	// ------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TEAM_SIZE);
	assign prdata = (paddr[2] == REG_TEAM_SIZE) ? {24'b0, team_q} : 32'b0;

	// Clamp the team size into 1..MAX_THREADS.
	always_comb begin
		if (team_q == 8'd0) begin
			team_eff = 8'd1;
		end else if (int'(team_q) > MAX_THREADS) begin
			team_eff = 8'(MAX_THREADS);
		end else begin
			team_eff = team_q;
		end
	end
	assign team_m1 = team_eff - 8'd1;

	// Thread slot is the thread number folded into the memory depth.
	always_comb begin
		for (int i = 0; i < NTID; i++) begin
			slot_tab[i] = SW'(i % MAX_THREADS);
		end
	end
	assign slot_w = slot_tab[thread_id];

	// ------------------------------------------------------------------------
	// Iteration count numerator: limit - first + step - sign(step).
	// ------------------------------------------------------------------------
	logic [CUR_W-1:0] num_w;
	logic [CUR_W-1:0] lim34;
	logic [CUR_W-1:0] fst34;
	logic [CUR_W-1:0] stp34_in;

	assign lim34    = {{2{loop_limit[IDX_W-1]}}, loop_limit};
	assign fst34    = {{2{loop_first[IDX_W-1]}}, loop_first};
	assign stp34_in = {{2{loop_step[IDX_W-1]}}, loop_step};
	assign num_w    = lim34 - fst34 + stp34_in
		+ (loop_step[IDX_W-1] ? CUR_W'(1) : {CUR_W{1'b1}});

	// ------------------------------------------------------------------------
	// Shared divider: count = |num| / |step|, then the default chunk
	// ceil(count / team).
	// ------------------------------------------------------------------------
	logic              div_go;
	logic [DIV_NW-1:0] div_dividend;
	logic [DIV_DW-1:0] div_divisor;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;

	always_comb begin
		div_go       = 1'b0;
		div_dividend = {1'b0, cnt_q} + DIV_NW'(team_m1);
		div_divisor  = {24'b0, team_eff};
		if (state_q == ST_CNT_GO) begin
			div_go       = 1'b1;
			div_dividend = num_q[CUR_W-1] ? (~num_q + CUR_W'(1)) : num_q;
			div_divisor  = step_q[IDX_W-1] ? (~step_q + IDX_W'(1)) : step_q;
		end else if (state_q == ST_CH_GO) begin
			div_go = 1'b1;
		end
	end

	lcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Count is positive only when numerator and step agree in sign.
	logic             cnt_pos;
	logic [CNT_W-1:0] cnt_w;
	logic             req_pos;

	assign cnt_pos = (num_q[CUR_W-1] == step_q[IDX_W-1]) && (num_q != '0) && (step_q != '0);
	assign cnt_w   = cnt_pos ? div_quo[CNT_W-1:0] : '0;
	assign req_pos = !req_q[IDX_W-1] && (req_q != '0);

	// ------------------------------------------------------------------------
	// Decide: pick the chunk [s, e) for the request and the state to write.
	// ------------------------------------------------------------------------
	logic [SUMW-1:0]  d_s;
	logic [SUMW-1:0]  d_sum;
	logic [CNT_W-1:0] d_cnt;
	logic [CNT_W-1:0] d_chunk;
	logic [IDX_W-1:0] d_base;
	logic [IDX_W-1:0] d_step;
	logic             d_gate;
	logic             d_ok;
	logic [CUR_W-1:0] d_e;

	always_comb begin
		d_s     = '0;
		d_cnt   = sh_count_q;
		d_chunk = sh_chunk_q;
		d_base  = sh_base_q;
		d_step  = sh_step_q;
		d_gate  = 1'b1;
		unique case (func_q) inside
			FN_STATIC_START: begin
				d_s     = SUMW'(p_q);
				d_cnt   = cnt_q;
				d_chunk = chunk_q;
				d_base  = first_q;
				d_step  = step_q;
				d_gate  = (cnt_q != '0);
			end
			FN_STATIC_NEXT: begin
				d_s     = SUMW'(rd_q.cursor) + SUMW'(p_q);
				d_cnt   = rd_q.count;
				d_chunk = rd_q.chunk;
				d_base  = rd_q.base;
				d_step  = rd_q.step;
			end
			FN_DYN_START, FN_DYN_NEXT: begin
				d_s    = SUMW'(sh_cursor_q);
				// a dynamic start of an empty loop gets nothing
				d_gate = (func_q == FN_DYN_NEXT) || (cnt_q != '0);
			end
			default: begin
				d_s = '0;
			end
		endcase
		d_sum = d_s + SUMW'(d_chunk);
		d_ok  = d_gate && (d_s < SUMW'(d_cnt));
		d_e   = (d_sum > SUMW'(d_cnt)) ? CUR_W'(d_cnt) : d_sum[CUR_W-1:0];
	end

	// Memory write-back: a static start always rewrites the thread's entry;
	// a static next only advances the cursor when it hands out a chunk.
	always_comb begin
		mem_we  = 1'b0;
		wr_data = rd_q;
		if (state_q == ST_DECIDE) begin
			if (func_q == FN_STATIC_START) begin
				mem_we         = 1'b1;
				wr_data.base   = first_q;
				wr_data.step   = step_q;
				wr_data.chunk  = chunk_q;
				wr_data.count  = cnt_q;
				wr_data.cursor = d_ok ? d_e : CUR_W'(cnt_q);
			end else if (func_q == FN_STATIC_NEXT) begin
				mem_we         = d_ok;
				wr_data.cursor = d_e;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= thr_mem[slot_w];
		end
		if (mem_we) begin
			thr_mem[slot_q] <= wr_data;
		end
	end

	// ------------------------------------------------------------------------
	// Index values: base + x * step over four 34x17 partial products.
	// mcnt 0..3 forms a product, mcnt 1..4 adds the previous one.
	// ------------------------------------------------------------------------
	logic [CUR_W-1:0] stp34;
	logic [CUR_W-1:0] m_x;
	logic [16:0]      m_y;
	logic [1:0]       m_tag;
	logic [CUR_W-1:0] m_add;
	logic [CUR_W-1:0] first_nx;
	logic [CUR_W-1:0] stop_nx;

	assign stp34 = {{2{stp_q[IDX_W-1]}}, stp_q};
	assign m_x   = mcnt_q[1] ? e_q : s_q;
	assign m_y   = mcnt_q[0] ? stp34[33:17] : stp34[16:0];
	assign m_tag = 2'(mcnt_q - 3'd1);
	assign m_add = m_tag[0] ? {mp_q[16:0], 17'b0} : mp_q;

	always_comb begin
		first_nx = first_acc_q;
		stop_nx  = stop_acc_q;
		if (mcnt_q != 3'd0) begin
			if (m_tag[1]) begin
				stop_nx = stop_acc_q + m_add;
			end else begin
				first_nx = first_acc_q + m_add;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer and control state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			team_q      <= 8'd1;
			done_q      <= 1'b0;
			mcnt_q      <= '0;
			sh_cursor_q <= '0;
			sh_count_q  <= '0;
			sh_base_q   <= '0;
			sh_step_q   <= IDX_W'(1);
			sh_chunk_q  <= CNT_W'(1);
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				team_q <= pwdata[7:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (func_t'(func) == FN_STATIC_NEXT || func_t'(func) == FN_DYN_NEXT) begin
							state_q <= ST_PLAN;
						end else begin
							state_q <= ST_CNT_GO;
						end
					end
				end
				ST_CNT_GO: begin
					state_q <= ST_CNT_WAIT;
				end
				ST_CNT_WAIT: begin
					if (div_done) begin
						if (req_pos || func_q == FN_DYN_START) begin
							state_q <= ST_PLAN;
						end else begin
							state_q <= ST_CH_GO;
						end
					end
				end
				ST_CH_GO: begin
					state_q <= ST_CH_WAIT;
				end
				ST_CH_WAIT: begin
					if (div_done) begin
						state_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					// thread 0 opens a new shared loop
					if (func_q == FN_DYN_START && tid_q == '0) begin
						sh_cursor_q <= '0;
						sh_count_q  <= cnt_q;
						sh_base_q   <= first_q;
						sh_step_q   <= step_q;
						sh_chunk_q  <= chunk_q;
					end
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if ((func_q == FN_DYN_START || func_q == FN_DYN_NEXT) && d_ok) begin
						sh_cursor_q <= d_sum[CUR_W-1:0];
					end
					if (d_ok) begin
						mcnt_q  <= '0;
						state_q <= ST_MUL;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd4) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func_t'(func);
			tid_q   <= thread_id;
			slot_q  <= slot_w;
			first_q <= loop_first;
			step_q  <= loop_step;
			req_q   <= chunk_request;
			num_q   <= num_w;
		end
		if (state_q == ST_CNT_WAIT && div_done) begin
			cnt_q <= cnt_w;
			if (req_pos) begin
				chunk_q <= CNT_W'(req_q);
			end else begin
				chunk_q <= CNT_W'(1);
			end
		end
		if (state_q == ST_CH_WAIT && div_done) begin
			chunk_q <= div_quo[CNT_W-1:0];
		end
		if (state_q == ST_PLAN) begin
			// static start: tid * chunk; static next: (team - 1) * chunk
			if (func_q == FN_STATIC_START) begin
				p_q <= PW'({1'b0, tid_q}) * PW'(chunk_q);
			end else begin
				p_q <= PW'(team_m1) * PW'(rd_q.chunk);
			end
		end
		if (state_q == ST_DECIDE) begin
			s_q           <= d_s[CUR_W-1:0];
			e_q           <= d_e;
			stp_q         <= d_step;
			first_acc_q   <= {{2{d_base[IDX_W-1]}}, d_base};
			stop_acc_q    <= {{2{d_base[IDX_W-1]}}, d_base};
			has_chunk_q   <= 1'b0;
			chunk_first_q <= '0;
			chunk_stop_q  <= '0;
		end
		if (state_q == ST_MUL) begin
			if (mcnt_q != 3'd4) begin
				mp_q <= m_x * {17'b0, m_y};
			end
			first_acc_q <= first_nx;
			stop_acc_q  <= stop_nx;
			if (mcnt_q == 3'd4) begin
				has_chunk_q   <= 1'b1;
				chunk_first_q <= first_nx;
				chunk_stop_q  <= stop_nx;
			end
		end
	end

	assign done        = done_q;
	assign has_chunk   = has_chunk_q;
	assign chunk_first = chunk_first_q;
	assign chunk_stop  = chunk_stop_q;

endmodule
